// ===== rtl/kr_pkg.sv =====
// Shared types and the keyword table for the keyword recognizer.
package kr_pkg;

   localparam int NUM_KW      = 22;
   localparam int KW_MAX_LEN  = 10;
   localparam int POS_W       = 4;
   localparam int CODE_W      = 5;

   typedef logic [7:0]          char_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [NUM_KW-1:0]   mask_type;
   // Character 0 of a keyword sits in the top byte.
   typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_type;

   localparam pos_type  POS_MAX    = 4'd11;
   localparam pos_type  POS_LAST   = 4'd9;
   localparam mask_type MASK_ALL   = {NUM_KW{1'b1}};
   localparam code_type CODE_IDENT = 5'd0;

   // Padded with spaces to a fixed 10 characters; padding is never compared.
   localparam kw_text_type KW_TEXT [NUM_KW] = '{
      "AND       ", "CASE      ", "CLENGTH   ", "CONCAT    ",
      "DEFAULT   ", "IF        ", "IFEMPTY   ", "IFNULL    ",
      "IN        ", "INSTR     ", "ISEMPTY   ", "ISNOTEMPTY",
      "ISNOTNULL ", "ISNULL    ", "LENGTH    ", "LIKE      ",
      "LOWER     ", "NOT       ", "NULL      ", "OR        ",
      "SUBSTR    ", "UPPER     "
   };

   localparam pos_type KW_LEN [NUM_KW] = '{
      4'd3, 4'd4, 4'd7, 4'd6, 4'd7, 4'd2, 4'd7, 4'd6, 4'd2, 4'd5, 4'd7,
      4'd10, 4'd9, 4'd6, 4'd6, 4'd4, 4'd5, 4'd3, 4'd4, 4'd2, 4'd6, 4'd5
   };

endpackage

// ===== rtl/kr_req_if.sv =====
// Input channel: one identifier byte per word.
interface kr_req_if;
   logic                valid;
   logic                ready;
   kr_pkg::char_type    char_byte;
   logic                last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

// ===== rtl/kr_rsp_if.sv =====
// Result channel: one token code per identifier.
interface kr_rsp_if;
   logic                valid;
   logic                ready;
   kr_pkg::code_type    token_code;

   modport source (output valid, output token_code, input ready);
   modport sink   (input valid, input token_code, output ready);
endinterface

// ===== rtl/kr_match.sv =====
// Per-keyword byte compare, candidate update and token code pick.
module kr_match (
   input  kr_pkg::pos_type   pos,
   input  kr_pkg::char_type  char_byte,
   input  kr_pkg::mask_type  mask_cur,
   output kr_pkg::mask_type  mask_nxt,
   output kr_pkg::code_type  code
);

   kr_pkg::pos_type pos_clip;
   kr_pkg::pos_type byte_sel;

   // Positions past the table width never match; clip only keeps the select legal.
   assign pos_clip = (pos > kr_pkg::POS_LAST) ? kr_pkg::POS_LAST : pos;
   assign byte_sel = kr_pkg::POS_LAST - pos_clip;

   always_comb begin
      for (int k = 0; k < kr_pkg::NUM_KW; k++) begin
         mask_nxt[k] = mask_cur[k] && (pos < kr_pkg::KW_LEN[k]) &&
                       (kr_pkg::KW_TEXT[k][byte_sel] == char_byte);
      end
   end

   // Lowest surviving keyword of matching length wins; one-byte words stay identifiers.
   always_comb begin
      code = kr_pkg::CODE_IDENT;
      for (int k = kr_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (pos != '0 && mask_nxt[k] && kr_pkg::KW_LEN[k] == pos + 4'd1) begin
            code = kr_pkg::code_type'(k + 1);
         end
      end
   end

endmodule

// ===== rtl/keyword_recognizer_core.sv =====
// Top level of the streaming keyword recognizer.
//
// Keyword recognizer: takes an identifier one byte per req word (last_char
// set on the final byte) and returns one rsp word per identifier with its
// token code: 0 for a plain identifier, 1..22 for AND, CASE, CLENGTH, CONCAT,
// DEFAULT, IF, IFEMPTY, IFNULL, IN, INSTR, ISEMPTY, ISNOTEMPTY, ISNOTNULL,
// ISNULL, LENGTH, LIKE, LOWER, NOT, NULL, OR, SUBSTR, UPPER. Matching is an
// exact byte compare (upper case only); one-byte words and words longer
// than ten bytes are identifiers. Throughput is one byte per clock while
// the result register can take each final byte: a byte lands in an input
// register, the 22 parallel compares and the code pick run in the
// following cycle, and the code is held in a result register. rsp valid
// rises once the last byte has passed the input and result registers. A
// stalled rsp only holds the pipe when a second final byte reaches the
// compare stage; the input register keeps accepting otherwise.
module keyword_recognizer_core (
   input  logic  clock,
   input  logic  reset,
   kr_req_if.sink   req,
   kr_rsp_if.source rsp
);

   // Input register
   logic               in_valid_ff;
   logic               in_valid_in;
   kr_pkg::char_type   in_char_ff;
   logic               in_last_ff;

   // Word state
   kr_pkg::pos_type    pos_ff;
   kr_pkg::pos_type    pos_in;
   kr_pkg::mask_type   mask_ff;
   kr_pkg::mask_type   mask_in;

   // Result register
   logic               out_valid_ff;
   logic               out_valid_in;
   kr_pkg::code_type   out_code_ff;

   kr_pkg::mask_type   mask_nxt;
   kr_pkg::code_type   code;
   logic               advance;
   logic               req_take;

   kr_match u_match (
      .pos       (pos_ff),
      .char_byte (in_char_ff),
      .mask_cur  (mask_ff),
      .mask_nxt  (mask_nxt),
      .code      (code)
   );

   // A final byte needs the result register free (or draining this cycle).
   assign advance  = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp.ready);

   always_comb begin
      pos_in  = pos_ff;
      mask_in = mask_ff;
      if (advance) begin
         if (in_last_ff) begin
            pos_in  = '0;
            mask_in = kr_pkg::MASK_ALL;
         end else begin
            pos_in  = (pos_ff < kr_pkg::POS_MAX) ? pos_ff + 4'd1 : pos_ff;
            mask_in = mask_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         mask_ff      <= kr_pkg::MASK_ALL;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         mask_ff      <= mask_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req.char_byte;
         in_last_ff <= req.last_char;
      end
      if (advance && in_last_ff) begin
         out_code_ff <= code;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.token_code = out_code_ff;

endmodule

// ===== dv/tb_keyword_recognizer_core.sv =====
// Self-checking testbench for keyword_recognizer_core: directed bytes, then random words.
`timescale 1ns / 1ps

module tb_keyword_recognizer_core;
   import kr_pkg::*;

   // Token codes in the block's alphabetical keyword order.
   typedef enum logic [CODE_W-1:0] {
      TOK_IDENT, TOK_AND, TOK_CASE, TOK_CLENGTH, TOK_CONCAT, TOK_DEFAULT,
      TOK_IF, TOK_IFEMPTY, TOK_IFNULL, TOK_IN, TOK_INSTR, TOK_ISEMPTY,
      TOK_ISNOTEMPTY, TOK_ISNOTNULL, TOK_ISNULL, TOK_LENGTH, TOK_LIKE,
      TOK_LOWER, TOK_NOT, TOK_NULL, TOK_OR, TOK_SUBSTR, TOK_UPPER
   } token_e;

   // Receiver stall styles, switched at the end of each receiver phase.
   typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

   // One input word as queued for the sender. 'typed' rows carry a fixed
   // expected code; all other final bytes are checked against the predictor.
   typedef struct packed {
      char_type data;
      logic     last;
      logic     typed;
      code_type code;
   } byte_item_t;

   localparam int       DIRECTED_N    = 22;
   localparam int       RANDOM_ITEMS  = 1200;
   localparam int       WORD_POS_SAT  = 11;      // position counter saturates here
   localparam int       CYCLE_LIMIT   = 200000;
   localparam int       DRAIN_CYCLES  = 16;      // drain after the last result is returned
   localparam int       HOLDOFF_START = 600;
   localparam int       HOLDOFF_LEN   = 400;
   localparam int       MAX_REPORTS   = 10;
   localparam char_type CHAR_A        = "A";
   localparam char_type CHAR_Z        = "Z";
   localparam char_type LOWER_BIT     = 8'h20;

   // Directed bytes: one-byte words ("A" and 8'hFF), a keyword, lower
   // case, an embedded zero byte, a second two-letter keyword and a word long
   // enough to saturate the position counter.
   localparam byte_item_t DIRECTED [DIRECTED_N] = '{
      '{"A",   1'b1, 1'b1, TOK_IDENT},   // single byte is never a keyword
      '{8'hFF, 1'b1, 1'b1, TOK_IDENT},
      '{"I",   1'b0, 1'b0, TOK_IDENT},
      '{"F",   1'b1, 1'b1, TOK_IF},
      '{"o",   1'b0, 1'b0, TOK_IDENT},
      '{"r",   1'b1, 1'b1, TOK_IDENT},   // lower case never matches
      '{"I",   1'b0, 1'b0, TOK_IDENT},
      '{8'h00, 1'b1, 1'b1, TOK_IDENT},   // zero byte is an ordinary byte
      '{"I",   1'b0, 1'b0, TOK_IDENT},
      '{"N",   1'b1, 1'b0, TOK_IDENT},   // predictor
      '{"I",   1'b0, 1'b0, TOK_IDENT},
      '{"S",   1'b0, 1'b0, TOK_IDENT},
      '{"N",   1'b0, 1'b0, TOK_IDENT},
      '{"O",   1'b0, 1'b0, TOK_IDENT},
      '{"T",   1'b0, 1'b0, TOK_IDENT},
      '{"E",   1'b0, 1'b0, TOK_IDENT},
      '{"M",   1'b0, 1'b0, TOK_IDENT},
      '{"P",   1'b0, 1'b0, TOK_IDENT},
      '{"T",   1'b0, 1'b0, TOK_IDENT},
      '{"Y",   1'b0, 1'b0, TOK_IDENT},
      '{"Z",   1'b0, 1'b0, TOK_IDENT},
      '{"Z",   1'b1, 1'b1, TOK_IDENT}    // 12 bytes: past the saturation point
   };

   // Keyword spellings for the predictor, index k is code k+1.
   string kw_words [NUM_KW] = '{
      "AND", "CASE", "CLENGTH", "CONCAT", "DEFAULT", "IF", "IFEMPTY",
      "IFNULL", "IN", "INSTR", "ISEMPTY", "ISNOTEMPTY", "ISNOTNULL",
      "ISNULL", "LENGTH", "LIKE", "LOWER", "NOT", "NULL", "OR", "SUBSTR",
      "UPPER"
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   kr_req_if req_bus ();
   kr_rsp_if rsp_bus ();

   keyword_recognizer_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #5 clock = ~clock;

   // Stimulus and scoreboard state.
   byte_item_t byte_q [$];        // every byte to send, in order
   code_type   token_q [$];       // token codes still owed by the block
   int         send_idx    = 0;   // next byte of byte_q to offer
   logic       req_took    = 1'b0;
   int         err_count   = 0;
   int         cycle_count = 0;

   // Predictor state: word position and surviving keyword candidates.
   int         match_pos   = 0;
   mask_type   live_mask   = '1;

   // Sender burst/gap bookkeeping (driver process only).
   int         burst_left  = 0;
   int         gap_left    = 0;

   // Receiver pattern and long hold-off.
   rx_mode_e   rx_mode     = RX_OPEN;
   int         rx_phase    = 0;
   int         rx_tick     = 0;
   int         holdoff_clock = 0;
   int         holdoff_left  = 0;

   // Step the predictor by one byte. Returns 1 when the byte closes a word,
   // with the expected token code in 'code'.
   function automatic bit classify_byte(input char_type b, input logic last,
                                        output code_type code);
      int       p;
      mask_type m;
      p    = (match_pos > WORD_POS_SAT) ? WORD_POS_SAT : match_pos;
      m    = live_mask;
      code = TOK_IDENT;
      // Drop every candidate that is too short or differs at this position.
      for (int k = 0; k < NUM_KW; k++)
         if (m[k] && (p >= kw_words[k].len() || char_type'(kw_words[k][p]) != b))
            m[k] = 1'b0;
      if (!last) begin
         if (p < WORD_POS_SAT)
            p++;
         match_pos = p;
         live_mask = m;
         return 1'b0;
      end
      // Final byte: the survivor whose length equals the word length wins.
      // A one-byte word never names a keyword.
      if (p >= 1)
         for (int k = 0; k < NUM_KW; k++)
            if (m[k] && kw_words[k].len() == p + 1 && code == TOK_IDENT)
               code = code_type'(k + 1);
      match_pos = 0;
      live_mask = '1;
      return 1'b1;
   endfunction

   function automatic char_type random_letter();
      return char_type'($urandom_range(CHAR_A, CHAR_Z));
   endfunction

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("%s", msg);
   endtask

   // Random words: mostly keywords, clean or slightly broken, then plain
   // letter runs and raw byte noise.
   task automatic load_random_words();
      char_type   w [$];
      string      s;
      int         r;
      int         n;
      byte_item_t it;
      while (byte_q.size() < DIRECTED_N + RANDOM_ITEMS) begin
         w.delete();
         r = $urandom_range(0, 99);
         s = kw_words[$urandom_range(0, NUM_KW - 1)];
         for (int i = 0; i < s.len(); i++)
            w.push_back(char_type'(s[i]));
         if (r < 50) begin
            // exact keyword
         end else if (r < 60) begin
            w[$urandom_range(0, w.size() - 1)] = random_letter();
         end else if (r < 67) begin
            void'(w.pop_back());     // every keyword has at least two bytes
         end else if (r < 74) begin
            w.push_back(random_letter());
         end else if (r < 79) begin
            foreach (w[i])
               w[i] = w[i] | LOWER_BIT;
         end else if (r < 90) begin
            w.delete();
            n = $urandom_range(1, 16);
            repeat (n) w.push_back(random_letter());
         end else begin
            w.delete();
            n = $urandom_range(1, 14);
            repeat (n) w.push_back(char_type'($urandom_range(0, 255)));
         end
         foreach (w[i]) begin
            it.data  = w[i];
            it.last  = (i == w.size() - 1);
            it.typed = 1'b0;
            it.code  = TOK_IDENT;
            byte_q.push_back(it);
         end
      end
   endtask

   // Scoreboard at the rising edge: retire results, then record accepted
   // input words and what they should produce.
   always @(posedge clock) begin
      code_type want;
      code_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.token_code;
            if (token_q.size() == 0) begin
               note_error($sformatf("unexpected token_code %0d, nothing pending", got));
            end else begin
               want = token_q.pop_front();
               if (got !== want)
                  note_error($sformatf("token_code mismatch: expected %0d, got %0d",
                                       want, got));
            end
         end
         req_took = req_bus.valid && req_bus.ready;
         if (req_took) begin
            if (classify_byte(byte_q[send_idx].data, byte_q[send_idx].last, want))
               token_q.push_back(byte_q[send_idx].typed ? byte_q[send_idx].code : want);
            send_idx++;
         end
      end
   end

   // Sender: bursts of random length separated by random gaps. A word that
   // is offered stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.char_byte <= '0;
         req_bus.last_char <= 1'b0;
      end else if (req_bus.valid && !req_took) begin
         // hold the pending word
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
      end else if (send_idx < byte_q.size()) begin
         req_bus.valid     <= 1'b1;
         req_bus.char_byte <= byte_q[send_idx].data;
         req_bus.last_char <= byte_q[send_idx].last;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) < 3)
               gap_left = 0;
            else if ($urandom_range(0, 9) == 0)
               gap_left = $urandom_range(10, 30);
            else
               gap_left = $urandom_range(1, 4);
         end else begin
            burst_left--;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // One long receiver hold-off, timed on its own cycle count, while the
   // sender keeps offering: the pipe fills and req.ready has to drop.
   always @(posedge clock) begin
      if (reset) begin
         holdoff_clock = 0;
      end else begin
         holdoff_clock++;
         if (holdoff_clock == HOLDOFF_START)
            holdoff_left = HOLDOFF_LEN;
         else if (holdoff_left > 0)
            holdoff_left--;
      end
   end

   // Receiver: picks a new random stall style at the end of each phase, including open stretches.
   always @(negedge clock) begin
      logic open;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_phase == 0) begin
            rx_mode  = rx_mode_e'($urandom_range(0, 3));
            rx_phase = 48;
         end
         rx_phase--;
         case (rx_mode)
            RX_OPEN:     open = 1'b1;
            RX_SPARSE:   open = ($urandom_range(0, 9) >= 3);
            RX_PERIODIC: open = ((rx_tick % 8) >= 3);
            default:     open = ($urandom_range(0, 9) >= 7);
         endcase
         rx_tick++;
         rsp_bus.ready <= open && (holdoff_left == 0);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.char_byte = '0;
      req_bus.last_char = 1'b0;
      rsp_bus.ready     = 1'b0;

      foreach (DIRECTED[i])
         byte_q.push_back(DIRECTED[i]);
      load_random_words();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All bytes accepted, all results returned, then a short drain in
      // which any stray result would be flagged.
      while (send_idx < byte_q.size())
         @(posedge clock);
      while (token_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0 && token_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
